### rtl/lsu_pkg.sv
package lsu_pkg;

  localparam logic KIND_EXEC = 1'b0;
  localparam logic KIND_READ = 1'b1;

  localparam logic [1:0] MEM_NONE  = 2'd0;
  localparam logic [1:0] MEM_READ  = 2'd1;
  localparam logic [1:0] MEM_WRITE = 2'd2;

  localparam logic [2:0] REG_C   = 3'd1;
  localparam logic [2:0] REG_MEM = 3'd6;
  localparam logic [2:0] REG_A   = 3'd7;

  localparam logic [1:0] PAIR_BC = 2'd0;
  localparam logic [1:0] PAIR_DE = 2'd1;
  localparam logic [1:0] PAIR_HL = 2'd2;
  localparam logic [1:0] PAIR_SP = 2'd3;

  localparam logic [3:0] TGT_BC = 4'd8;
  localparam logic [3:0] TGT_HL = 4'd10;
  localparam logic [3:0] TGT_SP = 4'd11;

  localparam logic [7:0] OP_HALT     = 8'h76;
  localparam logic [7:0] OP_LDH_U8_A = 8'hE0;
  localparam logic [7:0] OP_LDH_C_A  = 8'hE2;
  localparam logic [7:0] OP_LDH_A_U8 = 8'hF0;
  localparam logic [7:0] OP_LDH_A_C  = 8'hF2;
  localparam logic [7:0] OP_LD_U16_A = 8'hEA;
  localparam logic [7:0] OP_LD_A_U16 = 8'hFA;

  localparam logic [15:0] HIGH_PAGE = 16'hFF00;

  typedef logic [7:0][7:0] regfile_t;

  typedef struct packed {
    logic [1:0]  mem_request;
    logic [15:0] mem_address;
    logic [7:0]  mem_write_data;
    logic [4:0]  cycles;
    logic [1:0]  length;
    logic        illegal;
    logic        wb_valid;
    logic [3:0]  wb_target;
    logic [15:0] wb_value;
  } result_t;

  typedef struct packed {
    result_t    res;
    logic       load;
    logic [2:0] load_target;
  } decode_t;

endpackage

### rtl/lsu_decode.sv
module lsu_decode (
  input  logic [7:0]         instruction_code,
  input  logic [15:0]        immediate,
  input  lsu_pkg::regfile_t  regs,
  output lsu_pkg::decode_t   dec
);

  logic [2:0]  dst;
  logic [2:0]  src;
  logic [1:0]  sel;
  logic [15:0] hl;
  logic [15:0] pair_sel;
  logic [15:0] high_c;
  logic [15:0] high_u8;

  assign dst     = instruction_code[5:3];
  assign src     = instruction_code[2:0];
  assign sel     = instruction_code[5:4];
  assign hl      = {regs[4], regs[5]};
  assign high_c  = lsu_pkg::HIGH_PAGE | {8'h00, regs[lsu_pkg::REG_C]};
  assign high_u8 = lsu_pkg::HIGH_PAGE | {8'h00, immediate[7:0]};

  always_comb begin
    case (sel)
      lsu_pkg::PAIR_BC: pair_sel = {regs[0], regs[1]};
      lsu_pkg::PAIR_DE: pair_sel = {regs[2], regs[3]};
      default:          pair_sel = hl;
    endcase
  end

  always_comb begin
    dec = '0;
    if (instruction_code[7:6] == 2'b01) begin
      dec.res.length = 2'd1;
      if (instruction_code == lsu_pkg::OP_HALT) begin
        dec.res.cycles = 5'd8;
      end else if (dst == lsu_pkg::REG_MEM) begin
        dec.res.mem_request    = lsu_pkg::MEM_WRITE;
        dec.res.mem_address    = hl;
        dec.res.mem_write_data = regs[src];
        dec.res.cycles         = 5'd8;
      end else if (src == lsu_pkg::REG_MEM) begin
        dec.res.mem_request = lsu_pkg::MEM_READ;
        dec.res.mem_address = hl;
        dec.load            = 1'b1;
        dec.load_target     = dst;
        dec.res.cycles      = 5'd8;
      end else begin
        dec.res.wb_valid  = 1'b1;
        dec.res.wb_target = {1'b0, dst};
        dec.res.wb_value  = {8'h00, regs[src]};
        dec.res.cycles    = 5'd4;
      end
    end else if ((instruction_code & 8'hC7) == 8'h06) begin
      dec.res.length = 2'd2;
      if (dst == lsu_pkg::REG_MEM) begin
        dec.res.mem_request    = lsu_pkg::MEM_WRITE;
        dec.res.mem_address    = hl;
        dec.res.mem_write_data = immediate[7:0];
        dec.res.cycles         = 5'd12;
      end else begin
        dec.res.wb_valid  = 1'b1;
        dec.res.wb_target = {1'b0, dst};
        dec.res.wb_value  = {8'h00, immediate[7:0]};
        dec.res.cycles    = 5'd8;
      end
    end else if ((instruction_code & 8'hCF) == 8'h01) begin
      dec.res.wb_valid  = 1'b1;
      dec.res.wb_target = lsu_pkg::TGT_BC + {2'b00, sel};
      dec.res.wb_value  = immediate;
      dec.res.cycles    = 5'd12;
      dec.res.length    = 2'd3;
    end else if ((instruction_code & 8'hCF) == 8'h02 ||
                 (instruction_code & 8'hCF) == 8'h0A) begin
      dec.res.mem_address = pair_sel;
      if (instruction_code[3]) begin
        dec.res.mem_request = lsu_pkg::MEM_READ;
        dec.load            = 1'b1;
        dec.load_target     = lsu_pkg::REG_A;
      end else begin
        dec.res.mem_request    = lsu_pkg::MEM_WRITE;
        dec.res.mem_write_data = regs[lsu_pkg::REG_A];
      end
      if (sel == lsu_pkg::PAIR_HL) begin
        dec.res.wb_valid  = 1'b1;
        dec.res.wb_target = lsu_pkg::TGT_HL;
        dec.res.wb_value  = hl + 16'd1;
      end else if (sel == lsu_pkg::PAIR_SP) begin
        dec.res.wb_valid  = 1'b1;
        dec.res.wb_target = lsu_pkg::TGT_HL;
        dec.res.wb_value  = hl - 16'd1;
      end
      dec.res.cycles = 5'd8;
      dec.res.length = 2'd1;
    end else begin
      case (instruction_code)
        lsu_pkg::OP_LDH_U8_A: begin
          dec.res.mem_request    = lsu_pkg::MEM_WRITE;
          dec.res.mem_address    = high_u8;
          dec.res.mem_write_data = regs[lsu_pkg::REG_A];
          dec.res.cycles         = 5'd12;
          dec.res.length         = 2'd2;
        end
        lsu_pkg::OP_LDH_C_A: begin
          dec.res.mem_request    = lsu_pkg::MEM_WRITE;
          dec.res.mem_address    = high_c;
          dec.res.mem_write_data = regs[lsu_pkg::REG_A];
          dec.res.cycles         = 5'd8;
          dec.res.length         = 2'd1;
        end
        lsu_pkg::OP_LDH_A_U8: begin
          dec.res.mem_request = lsu_pkg::MEM_READ;
          dec.res.mem_address = high_u8;
          dec.load            = 1'b1;
          dec.load_target     = lsu_pkg::REG_A;
          dec.res.cycles      = 5'd12;
          dec.res.length      = 2'd2;
        end
        lsu_pkg::OP_LDH_A_C: begin
          dec.res.mem_request = lsu_pkg::MEM_READ;
          dec.res.mem_address = high_c;
          dec.load            = 1'b1;
          dec.load_target     = lsu_pkg::REG_A;
          dec.res.cycles      = 5'd8;
          dec.res.length      = 2'd1;
        end
        lsu_pkg::OP_LD_U16_A: begin
          dec.res.mem_request    = lsu_pkg::MEM_WRITE;
          dec.res.mem_address    = immediate;
          dec.res.mem_write_data = regs[lsu_pkg::REG_A];
          dec.res.cycles         = 5'd16;
          dec.res.length         = 2'd3;
        end
        lsu_pkg::OP_LD_A_U16: begin
          dec.res.mem_request = lsu_pkg::MEM_READ;
          dec.res.mem_address = immediate;
          dec.load            = 1'b1;
          dec.load_target     = lsu_pkg::REG_A;
          dec.res.cycles      = 5'd16;
          dec.res.length      = 2'd3;
        end
        default: dec.res.illegal = 1'b1;
      endcase
    end
  end

endmodule

### rtl/cpu_load_store_unit.sv
// Load/store unit for the 8-bit CPU's load instructions.
// Request channel (item_valid / item_stall): opcode selects the kind, 0 executes
// instruction_code with its immediate bytes, 1 delivers read_data for the
// pending load. Result channel (result_valid / result_stall): one result per
// request with the memory access, cycle cost, length, illegal flag and the
// register writeback.
// Each accepted request passes one input register, then decode, register file
// read and address forming into the result register; result_valid rises when
// the request moves in. Throughput is one request per clock while results are
// taken; the register file and the pending-load state update in the cycle a
// request moves into the result register, so the next request sees them at once.
// A load leaves its destination pending; an execute request while a load is
// pending, or read data with nothing pending, gives illegal and changes nothing.
// Reset (rst, synchronous) empties both registers, clears the register file
// and the pending load. While result_stall holds, the result stays put,
// the input register holds one more request and item_stall rises after that.
module cpu_load_store_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  output logic        item_stall,
  input  logic        opcode,
  input  logic [7:0]  instruction_code,
  input  logic [15:0] immediate,
  input  logic [7:0]  read_data,
  output logic        result_valid,
  input  logic        result_stall,
  output logic [1:0]  mem_request,
  output logic [15:0] mem_address,
  output logic [7:0]  mem_write_data,
  output logic [4:0]  cycles,
  output logic [1:0]  length,
  output logic        illegal,
  output logic        wb_valid,
  output logic [3:0]  wb_target,
  output logic [15:0] wb_value
);

  logic              s1_valid;
  logic              s1_kind;
  logic [7:0]        s1_code;
  logic [15:0]       s1_imm;
  logic [7:0]        s1_rdata;
  lsu_pkg::regfile_t regs;
  logic              pending;
  logic [2:0]        pending_target;
  lsu_pkg::result_t  result;
  lsu_pkg::result_t  result_next;
  lsu_pkg::decode_t  dec;
  logic              advance;
  logic              load_start;
  logic              load_done;

  assign advance    = s1_valid && (!result_valid || !result_stall);
  assign item_stall = s1_valid && !advance;

  lsu_decode u_decode (
    .instruction_code (s1_code),
    .immediate        (s1_imm),
    .regs             (regs),
    .dec              (dec)
  );

  always_comb begin
    result_next = '0;
    load_start  = 1'b0;
    load_done   = 1'b0;
    if (s1_kind == lsu_pkg::KIND_READ) begin
      if (pending) begin
        result_next.wb_valid  = 1'b1;
        result_next.wb_target = {1'b0, pending_target};
        result_next.wb_value  = {8'h00, s1_rdata};
        load_done             = 1'b1;
      end else begin
        result_next.illegal = 1'b1;
      end
    end else if (pending) begin
      result_next.illegal = 1'b1;
    end else begin
      result_next = dec.res;
      load_start  = dec.load;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!item_stall) begin
      s1_valid <= item_valid;
    end
    if (!item_stall && item_valid) begin
      s1_kind  <= opcode;
      s1_code  <= instruction_code;
      s1_imm   <= immediate;
      s1_rdata <= read_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
    if (advance) begin
      result <= result_next;
    end
  end

  // sp is never an address source, so its loads only show in the writeback
  always_ff @(posedge clk) begin
    if (rst) begin
      regs           <= '0;
      pending        <= 1'b0;
      pending_target <= '0;
    end else if (advance) begin
      if (result_next.wb_valid) begin
        if (!result_next.wb_target[3]) begin
          regs[result_next.wb_target[2:0]] <= result_next.wb_value[7:0];
        end else if (result_next.wb_target != lsu_pkg::TGT_SP) begin
          regs[{result_next.wb_target[1:0], 1'b0}] <= result_next.wb_value[15:8];
          regs[{result_next.wb_target[1:0], 1'b1}] <= result_next.wb_value[7:0];
        end
      end
      if (load_done) begin
        pending <= 1'b0;
      end else if (load_start) begin
        pending        <= 1'b1;
        pending_target <= dec.load_target;
      end
    end
  end

  assign mem_request    = result.mem_request;
  assign mem_address    = result.mem_address;
  assign mem_write_data = result.mem_write_data;
  assign cycles         = result.cycles;
  assign length         = result.length;
  assign illegal        = result.illegal;
  assign wb_valid       = result.wb_valid;
  assign wb_target      = result.wb_target;
  assign wb_value       = result.wb_value;

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    item_stall |-> s1_valid)
    else $error("request stall without a held request");

  a_read_sets_pending: assert property (@(posedge clk) disable iff (rst)
    advance && result_next.mem_request == lsu_pkg::MEM_READ |=> pending)
    else $error("memory read issued without a pending load");

  a_data_clears_pending: assert property (@(posedge clk) disable iff (rst)
    advance && s1_kind == lsu_pkg::KIND_READ |=> !pending)
    else $error("load still pending after read data");

  a_illegal_quiet: assert property (@(posedge clk) disable iff (rst)
    result_valid && illegal |-> !wb_valid && mem_request == lsu_pkg::MEM_NONE)
    else $error("illegal result carries an access or writeback");

  a_no_mem_target: assert property (@(posedge clk) disable iff (rst)
    result_valid && wb_valid |-> wb_target != {1'b0, lsu_pkg::REG_MEM})
    else $error("writeback to the memory operand slot");

endmodule

### tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam int RANDOM_REQS    = 725;
  localparam int QUIET_REQS     = 100;
  localparam int HOLD_AFTER     = 150;
  localparam int HOLD_CYCLES    = 60;
  localparam int DRAIN_CYCLES   = 8;
  localparam int WATCHDOG_LIMIT = 1000;

  localparam logic [2:0] REG_B = 3'd0;
  localparam logic [2:0] REG_D = 3'd2;
  localparam logic [2:0] REG_E = 3'd3;

  localparam logic [1:0] IND_HLI = 2'd2;
  localparam logic [1:0] IND_HLD = 2'd3;

  localparam logic [2:0] LO_LD_R_U8   = 3'b110;
  localparam logic [3:0] LO_LD_RR_U16 = 4'b0001;
  localparam logic [3:0] LO_ST_IND    = 4'b0010;
  localparam logic [3:0] LO_LD_IND    = 4'b1010;

  localparam logic [7:0] OP_UNKNOWN = 8'hD3;

  typedef struct packed {
    logic        kind;
    logic [7:0]  code;
    logic [15:0] imm;
    logic [7:0]  rd;
  } lsu_req_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_stall;
  logic        opcode = 1'b0;
  logic [7:0]  instruction_code = 8'd0;
  logic [15:0] immediate = 16'd0;
  logic [7:0]  read_data = 8'd0;
  logic        result_valid;
  logic        result_stall = 1'b0;
  logic [1:0]  mem_request;
  logic [15:0] mem_address;
  logic [7:0]  mem_write_data;
  logic [4:0]  cycles;
  logic [1:0]  length;
  logic        illegal;
  logic        wb_valid;
  logic [3:0]  wb_target;
  logic [15:0] wb_value;

  cpu_load_store_unit DUT (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_stall(item_stall),
    .opcode(opcode),
    .instruction_code(instruction_code),
    .immediate(immediate),
    .read_data(read_data),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .mem_request(mem_request),
    .mem_address(mem_address),
    .mem_write_data(mem_write_data),
    .cycles(cycles),
    .length(length),
    .illegal(illegal),
    .wb_valid(wb_valid),
    .wb_target(wb_target),
    .wb_value(wb_value)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // shadow cpu state
  logic [7:0]  gpr [8] = '{default: 8'd0};
  logic [15:0] sp_shadow = 16'd0;
  logic        load_outstanding = 1'b0;
  logic [2:0]  load_dest = 3'd0;

  lsu_req_t          pending_reqs[$];
  lsu_pkg::result_t  expected_results[$];

  int               error_count = 0;
  int               results_seen = 0;
  int               idle_cycles = 0;
  int               tx_gap = 0;
  int               rx_gap = 0;
  int               hold_left = 0;
  bit               hold_done = 1'b0;
  logic             req_taken = 1'b0;
  logic             quiet = 1'b0;
  logic             rx_holding = 1'b0;
  lsu_req_t         next_req;
  lsu_pkg::result_t want;

  function automatic logic [15:0] pair_value(logic [1:0] p);
    case (p)
      lsu_pkg::PAIR_BC: return {gpr[0], gpr[1]};
      lsu_pkg::PAIR_DE: return {gpr[2], gpr[3]};
      lsu_pkg::PAIR_HL: return {gpr[4], gpr[5]};
      default: return sp_shadow;
    endcase
  endfunction

  function automatic void write_gpr(inout lsu_pkg::result_t r, input logic [2:0] idx,
                                    input logic [7:0] v);
    gpr[idx] = v;
    r.wb_valid = 1'b1;
    r.wb_target = {1'b0, idx};
    r.wb_value = {8'd0, v};
  endfunction

  function automatic void write_pair(inout lsu_pkg::result_t r, input logic [1:0] p,
                                     input logic [15:0] v);
    if (p == lsu_pkg::PAIR_SP) begin
      sp_shadow = v;
    end else begin
      gpr[{p, 1'b0}] = v[15:8];
      gpr[{p, 1'b1}] = v[7:0];
    end
    r.wb_valid = 1'b1;
    r.wb_target = lsu_pkg::TGT_BC + {2'd0, p};
    r.wb_value = v;
  endfunction

  function automatic void store(inout lsu_pkg::result_t r, input logic [15:0] addr,
                                input logic [7:0] data);
    r.mem_request = lsu_pkg::MEM_WRITE;
    r.mem_address = addr;
    r.mem_write_data = data;
  endfunction

  function automatic void start_read(inout lsu_pkg::result_t r, input logic [15:0] addr,
                                     input logic [2:0] dst);
    r.mem_request = lsu_pkg::MEM_READ;
    r.mem_address = addr;
    load_outstanding = 1'b1;
    load_dest = dst;
  endfunction

  function automatic lsu_pkg::result_t predict_load_store(lsu_req_t q);
    lsu_pkg::result_t r;
    logic [15:0]      hl;
    logic [7:0]       acc;
    logic [2:0]       dst;
    logic [2:0]       src;
    logic [1:0]       sel;
    logic [15:0]      addr;
    r = '0;
    hl = pair_value(lsu_pkg::PAIR_HL);
    acc = gpr[lsu_pkg::REG_A];
    dst = q.code[5:3];
    src = q.code[2:0];
    sel = q.code[5:4];
    if (q.kind == lsu_pkg::KIND_READ) begin
      if (load_outstanding) begin
        write_gpr(r, load_dest, q.rd);
        load_outstanding = 1'b0;
      end else begin
        r.illegal = 1'b1;
      end
    end else if (load_outstanding) begin
      r.illegal = 1'b1;
    end else if (q.code[7:6] == 2'b01) begin
      r.length = 2'd1;
      r.cycles = 5'd8;
      if (q.code != lsu_pkg::OP_HALT) begin
        if (dst == lsu_pkg::REG_MEM) begin
          store(r, hl, gpr[src]);
        end else if (src == lsu_pkg::REG_MEM) begin
          start_read(r, hl, dst);
        end else begin
          write_gpr(r, dst, gpr[src]);
          r.cycles = 5'd4;
        end
      end
    end else if (q.code[7:6] == 2'b00 && src == LO_LD_R_U8) begin
      r.length = 2'd2;
      if (dst == lsu_pkg::REG_MEM) begin
        store(r, hl, q.imm[7:0]);
        r.cycles = 5'd12;
      end else begin
        write_gpr(r, dst, q.imm[7:0]);
        r.cycles = 5'd8;
      end
    end else if (q.code[7:6] == 2'b00 && q.code[3:0] == LO_LD_RR_U16) begin
      write_pair(r, sel, q.imm);
      r.cycles = 5'd12;
      r.length = 2'd3;
    end else if (q.code[7:6] == 2'b00 &&
                 (q.code[3:0] == LO_ST_IND || q.code[3:0] == LO_LD_IND)) begin
      addr = (sel == IND_HLI || sel == IND_HLD) ? hl : pair_value(sel);
      if (q.code[3]) start_read(r, addr, lsu_pkg::REG_A);
      else store(r, addr, acc);
      if (sel == IND_HLI) write_pair(r, lsu_pkg::PAIR_HL, hl + 16'd1);
      else if (sel == IND_HLD) write_pair(r, lsu_pkg::PAIR_HL, hl - 16'd1);
      r.cycles = 5'd8;
      r.length = 2'd1;
    end else begin
      case (q.code)
        lsu_pkg::OP_LDH_U8_A: begin
          store(r, lsu_pkg::HIGH_PAGE | {8'd0, q.imm[7:0]}, acc);
          r.cycles = 5'd12;
          r.length = 2'd2;
        end
        lsu_pkg::OP_LDH_C_A: begin
          store(r, lsu_pkg::HIGH_PAGE | {8'd0, gpr[lsu_pkg::REG_C]}, acc);
          r.cycles = 5'd8;
          r.length = 2'd1;
        end
        lsu_pkg::OP_LDH_A_U8: begin
          start_read(r, lsu_pkg::HIGH_PAGE | {8'd0, q.imm[7:0]}, lsu_pkg::REG_A);
          r.cycles = 5'd12;
          r.length = 2'd2;
        end
        lsu_pkg::OP_LDH_A_C: begin
          start_read(r, lsu_pkg::HIGH_PAGE | {8'd0, gpr[lsu_pkg::REG_C]}, lsu_pkg::REG_A);
          r.cycles = 5'd8;
          r.length = 2'd1;
        end
        lsu_pkg::OP_LD_U16_A: begin
          store(r, q.imm, acc);
          r.cycles = 5'd16;
          r.length = 2'd3;
        end
        lsu_pkg::OP_LD_A_U16: begin
          start_read(r, q.imm, lsu_pkg::REG_A);
          r.cycles = 5'd16;
          r.length = 2'd3;
        end
        default: r.illegal = 1'b1;
      endcase
    end
    return r;
  endfunction

  // opcode builders
  function automatic logic [7:0] op_ld_r_r(logic [2:0] dst, logic [2:0] src);
    return {2'b01, dst, src};
  endfunction

  function automatic logic [7:0] op_ld_r_u8(logic [2:0] dst);
    return {2'b00, dst, LO_LD_R_U8};
  endfunction

  function automatic logic [7:0] op_ld_rr_u16(logic [1:0] p);
    return {2'b00, p, LO_LD_RR_U16};
  endfunction

  function automatic logic [7:0] op_st_ind(logic [1:0] sel);
    return {2'b00, sel, LO_ST_IND};
  endfunction

  function automatic logic [7:0] op_ld_ind(logic [1:0] sel);
    return {2'b00, sel, LO_LD_IND};
  endfunction

  function automatic bit is_known_op(logic [7:0] c);
    return c[7:6] == 2'b01 ||
           (c[7:6] == 2'b00 && (c[2:0] == LO_LD_R_U8 || c[3:0] == LO_LD_RR_U16 ||
                                c[3:0] == LO_ST_IND || c[3:0] == LO_LD_IND)) ||
           c == lsu_pkg::OP_LDH_U8_A || c == lsu_pkg::OP_LDH_C_A ||
           c == lsu_pkg::OP_LDH_A_U8 || c == lsu_pkg::OP_LDH_A_C ||
           c == lsu_pkg::OP_LD_U16_A || c == lsu_pkg::OP_LD_A_U16;
  endfunction

  function automatic bit reads_memory(logic [7:0] c);
    return (c[7:6] == 2'b01 && c[2:0] == lsu_pkg::REG_MEM && c != lsu_pkg::OP_HALT) ||
           (c[7:6] == 2'b00 && c[3:0] == LO_LD_IND) ||
           c == lsu_pkg::OP_LDH_A_U8 || c == lsu_pkg::OP_LDH_A_C ||
           c == lsu_pkg::OP_LD_A_U16;
  endfunction

  function automatic logic [15:0] pick_imm();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic add_exec(logic [7:0] code, logic [15:0] imm);
    lsu_req_t r;
    r.kind = lsu_pkg::KIND_EXEC;
    r.code = code;
    r.imm = imm;
    r.rd = 8'($urandom);
    pending_reqs.push_back(r);
  endtask

  task automatic add_read(logic [7:0] rd);
    lsu_req_t r;
    r.kind = lsu_pkg::KIND_READ;
    r.code = 8'($urandom);
    r.imm = 16'($urandom);
    r.rd = rd;
    pending_reqs.push_back(r);
  endtask

  task automatic report_error(string msg);
    $display("ERROR at %0t: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(string name, int idx, logic [15:0] got, logic [15:0] exp_val);
    if (got !== exp_val)
      report_error($sformatf("result %0d %s got %h expected %h", idx, name, got, exp_val));
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst) begin
      quiet <= (pending_reqs.size() < QUIET_REQS);
      if (!item_valid || req_taken) begin
        if (tx_gap == 0 && !quiet && !rx_holding && $urandom_range(0, 5) == 0)
          tx_gap = $urandom_range(1, 16);
        if (tx_gap > 0 || pending_reqs.size() == 0) begin
          if (tx_gap > 0) tx_gap--;
          item_valid <= 1'b0;
        end else begin
          next_req = pending_reqs.pop_front();
          item_valid <= 1'b1;
          opcode <= next_req.kind;
          instruction_code <= next_req.code;
          immediate <= next_req.imm;
          read_data <= next_req.rd;
        end
      end
    end
  end

  // result receiver, with one long hold-off to back the unit up
  always @(negedge clk) begin
    if (!rst) begin
      if (hold_left == 0 && !hold_done && results_seen >= HOLD_AFTER) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        result_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(1, 16) - 1;
        result_stall <= 1'b1;
      end else begin
        result_stall <= 1'b0;
      end
      rx_holding <= (hold_left > 0);
    end
  end

  // prediction, checking and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      req_taken <= item_valid && !item_stall;
      if (item_valid && !item_stall)
        expected_results.push_back(predict_load_store({opcode, instruction_code,
                                                       immediate, read_data}));
      if (result_valid && !result_stall) begin
        results_seen++;
        if (expected_results.size() == 0) begin
          report_error($sformatf("result %0d with no request outstanding", results_seen));
        end else begin
          want = expected_results.pop_front();
          check_field("mem_request", results_seen, 16'(mem_request),
                      16'(want.mem_request));
          check_field("mem_address", results_seen, mem_address, want.mem_address);
          check_field("mem_write_data", results_seen, 16'(mem_write_data),
                      16'(want.mem_write_data));
          check_field("cycles", results_seen, 16'(cycles), 16'(want.cycles));
          check_field("length", results_seen, 16'(length), 16'(want.length));
          check_field("illegal", results_seen, 16'(illegal), 16'(want.illegal));
          check_field("wb_valid", results_seen, 16'(wb_valid), 16'(want.wb_valid));
          check_field("wb_target", results_seen, 16'(wb_target), 16'(want.wb_target));
          check_field("wb_value", results_seen, wb_value, want.wb_value);
        end
      end
      if ((item_valid && !item_stall) || (result_valid && !result_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d cycles without progress", idle_cycles);
        $display("cpu_load_store_unit test failed");
        $finish;
      end
    end
  end

  initial begin
    int          pick;
    bit          gen_pending;
    logic [7:0]  code;
    gen_pending = 1'b0;

    // directed requests
    add_exec(op_ld_rr_u16(lsu_pkg::PAIR_BC), 16'hFFFF);
    add_exec(op_ld_rr_u16(lsu_pkg::PAIR_DE), 16'h8001);
    add_exec(op_ld_rr_u16(lsu_pkg::PAIR_HL), 16'hFFFF);
    add_exec(op_ld_rr_u16(lsu_pkg::PAIR_SP), 16'h0000);
    add_exec(op_ld_r_u8(lsu_pkg::REG_A), 16'h12FF);
    add_exec(op_st_ind(IND_HLI), pick_imm());
    add_exec(op_st_ind(IND_HLD), pick_imm());
    add_exec(op_ld_ind(IND_HLI), pick_imm());
    add_read(8'hFF);
    add_exec(op_ld_ind(IND_HLD), pick_imm());
    add_read(8'h00);
    add_exec(lsu_pkg::OP_HALT, pick_imm());
    add_exec(op_ld_r_u8(lsu_pkg::REG_MEM), 16'h00A5);
    add_exec(op_ld_r_r(REG_B, lsu_pkg::REG_MEM), pick_imm());
    add_read(8'h5A);
    add_exec(op_ld_r_r(lsu_pkg::REG_MEM, lsu_pkg::REG_C), pick_imm());
    add_exec(op_ld_r_r(REG_D, REG_E), pick_imm());
    add_exec(lsu_pkg::OP_LDH_U8_A, 16'h00FF);
    add_exec(lsu_pkg::OP_LDH_C_A, pick_imm());
    add_exec(lsu_pkg::OP_LDH_A_U8, 16'hFF00);
    add_exec(OP_UNKNOWN, pick_imm());
    add_read(8'h80);
    add_exec(lsu_pkg::OP_LD_U16_A, 16'hFFFF);
    add_exec(lsu_pkg::OP_LD_A_U16, 16'h0000);
    add_read(8'h3C);
    add_exec(lsu_pkg::OP_LDH_A_C, pick_imm());
    add_read(8'hC3);
    add_exec(op_st_ind(lsu_pkg::PAIR_BC), pick_imm());
    add_exec(op_ld_ind(lsu_pkg::PAIR_DE), pick_imm());
    add_read(8'h7E);
    add_read(8'h33);
    add_exec(OP_UNKNOWN, pick_imm());

    // random requests, mostly known opcodes with read data after each load, plus some stray and broken ones
    for (int n = 0; n < RANDOM_REQS; n++) begin
      pick = $urandom_range(0, 99);
      if (gen_pending && pick < 90) begin
        add_read(8'($urandom));
        gen_pending = 1'b0;
      end else if (pick < 85) begin
        do code = 8'($urandom); while (!is_known_op(code));
        add_exec(code, pick_imm());
        if (reads_memory(code)) gen_pending = 1'b1;
      end else if (pick < 93) begin
        code = 8'($urandom);
        add_exec(code, pick_imm());
        if (reads_memory(code)) gen_pending = 1'b1;
      end else begin
        add_read(8'($urandom));
        gen_pending = 1'b0;
      end
    end

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    while (pending_reqs.size() != 0 || item_valid || expected_results.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (expected_results.size() != 0)
      report_error($sformatf("%0d results never arrived", expected_results.size()));
    if (error_count == 0) begin
      $display("cpu_load_store_unit test passed");
    end else begin
      $display("cpu_load_store_unit test failed");
    end
    $finish;
  end

endmodule
